>>> hdl/u8pe_pkg.sv
// Package for the UTF-8 URL percent encoder: item kinds, sizes and the
// character helpers shared by the pipeline. No dependencies.
`default_nettype none

package u8pe_pkg;

	localparam int CpWidth   = 31;
	localparam int CharWidth = 7;
	localparam int MaxBytes  = 6;
	localparam int MaxChars  = 3 * MaxBytes;
	localparam int CntWidth  = $clog2(MaxChars + 1);

	localparam logic [CharWidth-1:0] CharPct = 7'h25;

	typedef logic [2:0]           nbytes_t;
	typedef logic [7:0]           byte_t;
	typedef logic [CharWidth-1:0] char_t;
	typedef logic [CntWidth-1:0]  cnt_t;

	// How a code point is rendered
	typedef enum logic [1:0] {
		KIND_NONE,  // zero code point, no characters
		KIND_PASS,  // letter or digit, one character as is
		KIND_PCT    // percent-encoded UTF-8 bytes
	} kind_t;

	function automatic char_t hex_char(input logic [3:0] nib);
		char_t c;
		if (nib < 4'd10) begin
			c = 7'h30 + {3'b000, nib};
		end else begin
			c = 7'h37 + {3'b000, nib};
		end
		return c;
	endfunction

	// Lead byte prefix for a multi-byte sequence
	function automatic byte_t lead_byte(input nbytes_t nb);
		byte_t b;
		unique case (nb)
			3'd2:    b = 8'hC0;
			3'd3:    b = 8'hE0;
			3'd4:    b = 8'hF0;
			3'd5:    b = 8'hF8;
			3'd6:    b = 8'hFC;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

>>> hdl/utf8_percent_encoder.sv
// UTF-8 URL percent encoder top level: three-stage pipeline plus output shifter.
// Depends on u8pe_pkg.
`default_nettype none

// Takes one 31-bit code point per item and emits its URL-encoded text, one
// ASCII character per output item, with last_char set on the final one.
// Letters and digits come out as themselves; any other non-zero code point
// becomes one to six UTF-8 bytes, each sent as '%' and two upper-case hex
// digits; code point zero produces nothing. An item passes three register
// stages (classify, byte split, character build) and then loads the output
// shifter, from which its first character is shown. The input takes a new
// code point every cycle as long as the output keeps up; the output shifter
// sends one character per cycle while out_ready is high, one for a letter or
// digit or three per UTF-8 byte (3 to 18), and that shifter sets the
// sustained rate. A zero code point uses one slot in each stage and never
// enters the shifter.
module utf8_percent_encoder (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  [u8pe_pkg::CpWidth-1:0]   code_point,
	input  wire                            in_valid,
	output logic                           in_ready,
	output logic [u8pe_pkg::CharWidth-1:0] out_char,
	output logic                           last_char,
	output logic                           out_valid,
	input  wire                            out_ready
);

	// ---------------- stage 1: classify ----------------
	logic                         v_s1;
	logic [u8pe_pkg::CpWidth-1:0] cp_s1;
	u8pe_pkg::nbytes_t            nb_s1;
	u8pe_pkg::kind_t              kind_s1;

	logic                         adv1, adv2, adv3;
	logic                         is_alnum;
	u8pe_pkg::nbytes_t            nb_in;
	u8pe_pkg::kind_t              kind_in;

	always_comb begin
		is_alnum = (code_point >= 31'h61 && code_point <= 31'h7A) ||
		           (code_point >= 31'h41 && code_point <= 31'h5A) ||
		           (code_point >= 31'h30 && code_point <= 31'h39);
		if (code_point < 31'h80) begin
			nb_in = 3'd1;
		end else if (code_point < 31'h800) begin
			nb_in = 3'd2;
		end else if (code_point < 31'h10000) begin
			nb_in = 3'd3;
		end else if (code_point < 31'h200000) begin
			nb_in = 3'd4;
		end else if (code_point < 31'h4000000) begin
			nb_in = 3'd5;
		end else begin
			nb_in = 3'd6;
		end
		if (code_point == '0) begin
			kind_in = u8pe_pkg::KIND_NONE;
		end else if (is_alnum) begin
			kind_in = u8pe_pkg::KIND_PASS;
		end else begin
			kind_in = u8pe_pkg::KIND_PCT;
		end
	end

	assign in_ready = adv1;
	assign adv1     = !v_s1 || adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			cp_s1   <= code_point;
			nb_s1   <= nb_in;
			kind_s1 <= kind_in;
		end
	end

	// ---------------- stage 2: split into bytes ----------------
	logic                          v_s2;
	u8pe_pkg::byte_t               bytes_s2 [u8pe_pkg::MaxBytes];
	u8pe_pkg::nbytes_t             nb_s2;
	u8pe_pkg::kind_t               kind_s2;
	u8pe_pkg::char_t               ch_s2;

	logic [5:0]                    grp   [u8pe_pkg::MaxBytes];
	u8pe_pkg::byte_t               bytes [u8pe_pkg::MaxBytes];
	u8pe_pkg::nbytes_t             top_idx;

	always_comb begin
		// six-bit groups, least significant first; the top one has one bit
		for (int k = 0; k < u8pe_pkg::MaxBytes - 1; k++) begin
			grp[k] = cp_s1[6*k +: 6];
		end
		grp[u8pe_pkg::MaxBytes-1] = {5'b00000, cp_s1[30]};

		top_idx = nb_s1 - 3'd1;
		if (nb_s1 == 3'd1) begin
			bytes[0] = {1'b0, cp_s1[6:0]};
		end else begin
			bytes[0] = u8pe_pkg::lead_byte(nb_s1) | {2'b00, grp[top_idx]};
		end
		for (int i = 1; i < u8pe_pkg::MaxBytes; i++) begin
			if (3'(i) < nb_s1) begin
				bytes[i] = {2'b10, grp[top_idx - 3'(i)]};
			end else begin
				bytes[i] = 8'h80;
			end
		end
	end

	assign adv2 = !v_s2 || adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			bytes_s2 <= bytes;
			nb_s2    <= nb_s1;
			kind_s2  <= kind_s1;
			ch_s2    <= cp_s1[6:0];
		end
	end

	// ---------------- stage 3: build characters ----------------
	logic                          v_s3;
	u8pe_pkg::char_t               chars_s3 [u8pe_pkg::MaxChars];
	u8pe_pkg::cnt_t                cnt_s3;

	u8pe_pkg::char_t               chars [u8pe_pkg::MaxChars];
	u8pe_pkg::cnt_t                cnt;
	logic                          s3_take;
	logic                          shf_ready;

	always_comb begin
		for (int j = 0; j < u8pe_pkg::MaxBytes; j++) begin
			chars[3*j]     = u8pe_pkg::CharPct;
			chars[3*j + 1] = u8pe_pkg::hex_char(bytes_s2[j][7:4]);
			chars[3*j + 2] = u8pe_pkg::hex_char(bytes_s2[j][3:0]);
		end
		unique case (kind_s2)
			u8pe_pkg::KIND_NONE: begin
				cnt = '0;
			end
			u8pe_pkg::KIND_PASS: begin
				chars[0] = ch_s2;
				cnt      = u8pe_pkg::cnt_t'(1);
			end
			u8pe_pkg::KIND_PCT: begin
				cnt = u8pe_pkg::cnt_t'(nb_s2) * u8pe_pkg::cnt_t'(3);
			end
			default: begin
				cnt = '0;
			end
		endcase
	end

	// drop empty items without waiting on the shifter
	assign s3_take = v_s3 && (cnt_s3 == '0 || shf_ready);
	assign adv3    = !v_s3 || s3_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			chars_s3 <= chars;
			cnt_s3   <= cnt;
		end
	end

	// ---------------- output shifter ----------------
	u8pe_pkg::char_t               buf_q [u8pe_pkg::MaxChars];
	u8pe_pkg::cnt_t                cnt_q;
	logic                          load;
	logic                          take;

	assign out_valid = cnt_q != '0;
	assign out_char  = buf_q[0];
	assign last_char = cnt_q == u8pe_pkg::cnt_t'(1);
	assign take      = out_valid && out_ready;
	assign shf_ready = cnt_q == '0 || (last_char && out_ready);
	assign load      = s3_take && cnt_s3 != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= cnt_s3;
		end else if (take) begin
			cnt_q <= cnt_q - u8pe_pkg::cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= chars_s3;
		end else if (take) begin
			// advance to the next character
			for (int i = 0; i < u8pe_pkg::MaxChars - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= u8pe_pkg::cnt_t'(u8pe_pkg::MaxChars))
		else $error("output count out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == '0 || (cnt_q == u8pe_pkg::cnt_t'(1) && out_ready)))
		else $error("shifter loaded while characters remain");

	a_cnt_shape: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (cnt_s3 == 5'd0 || cnt_s3 == 5'd1 || cnt_s3 == 5'd6 ||
		          cnt_s3 == 5'd9 || cnt_s3 == 5'd12 || cnt_s3 == 5'd15 ||
		          cnt_s3 == 5'd18 || cnt_s3 == 5'd3))
		else $error("character count not a legal expansion");

	a_pct_first: assert property (@(posedge clk) disable iff (!arst_n)
		load && cnt_s3 != 5'd1 |=> out_char == u8pe_pkg::CharPct)
		else $error("encoded run does not start with percent");
`endif

endmodule

`default_nettype wire
